FILE: src/bsirq_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the bank switch scanline irq mapper
package bsirq_pkg;

    // result kinds
    typedef enum logic [1:0] {
        KIND_PATTERN = 2'd0,
        KIND_PROGRAM = 2'd1,
        KIND_MIRROR  = 2'd2,
        KIND_IRQ     = 2'd3
    } t_kind;

    // register decode: address bits 15, 14, 13 and 0
    localparam logic [15:0] ADDR_MASK      = 16'hE001;
    localparam logic [15:0] REG_COMMAND    = 16'h8000;
    localparam logic [15:0] REG_DATA       = 16'h8001;
    localparam logic [15:0] REG_MIRROR     = 16'hA000;
    localparam logic [15:0] REG_RELOAD     = 16'hC000;
    localparam logic [15:0] REG_RELOAD_REQ = 16'hC001;
    localparam logic [15:0] REG_IRQ_OFF    = 16'hE000;
    localparam logic [15:0] REG_IRQ_ON     = 16'hE001;

    // command codes (low nibble of the command byte)
    localparam logic [3:0] CMD_PAT_PAIR0 = 4'd0;
    localparam logic [3:0] CMD_PAT_PAIR2 = 4'd1;
    localparam logic [3:0] CMD_PAT_4     = 4'd2;
    localparam logic [3:0] CMD_PAT_5     = 4'd3;
    localparam logic [3:0] CMD_PAT_6     = 4'd4;
    localparam logic [3:0] CMD_PAT_7     = 4'd5;
    localparam logic [3:0] CMD_PRG_A     = 4'd6;
    localparam logic [3:0] CMD_PRG_B     = 4'd7;
    localparam logic [3:0] CMD_PAT_1     = 4'd8;
    localparam logic [3:0] CMD_PAT_3     = 4'd9;
    localparam logic [3:0] CMD_PRG_C     = 4'd15;

    // first line on which an hblank is ignored
    localparam logic [8:0] LINE_LIMIT = 9'd241;

    // one classified item: one or two results sharing kind and bank
    typedef struct packed {
        t_kind      kind;
        logic [2:0] slot_a;
        logic [2:0] slot_b;
        logic [7:0] bank;
        logic       two;
    } t_job;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

FILE: src/bank_switch_scanline_irq_mapper_top.sv
`timescale 1ns / 1ps
// top level of the bank switch scanline irq mapper
//
// Takes one item per cycle: a cpu register write (address bits 15, 14, 13
// and 0 decoded) or an hblank event. The front end decodes the item, updates
// the command byte, reload latch, irq enable and scanline counter in the
// same cycle, and turns any item that has results, mirroring writes among
// them, into a job in a short queue (QUEUE_DEPTH entries). The back end pulls
// jobs and sends one result item per cycle, while i_out_stall is low, through
// a registered output; a write to the data register under command 0 or 1
// yields two pattern-slot results, everything else at most one. Items with no
// result (command, reload and irq enable writes, data writes under unused
// command codes, most hblanks, undecoded addresses) never enter the queue.
// Input is stalled only while the queue is full, so the sustained rate is one
// item per cycle, bounded by the output port at one result per cycle. An
// accepted item is written into the queue and then loaded into the output
// register. o_last marks the final result of each item.
module bank_switch_scanline_irq_mapper_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_value,
    input  logic [8:0]  i_scanline,
    input  logic        i_render_on,
    // result item channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [2:0]  o_slot,
    output logic [7:0]  o_bank,
    output logic        o_last
);
    import bsirq_pkg::*;

    t_job      push_job;
    t_job      head_job;
    logic      push;
    logic      pop;
    t_q_status q_status;

    // decode and state update
    bsirq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_address   (i_address),
        .i_value     (i_value),
        .i_scanline  (i_scanline),
        .i_render_on (i_render_on),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_job       (push_job)
    );

    // decoupling queue
    bsirq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_job    (head_job),
        .o_status (q_status)
    );

    // result sequencing and output register
    bsirq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_kind      (o_kind),
        .o_slot      (o_slot),
        .o_bank      (o_bank),
        .o_last      (o_last)
    );

    // queue cannot be full and empty at once
    a_queue_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue reports full and empty together");

    // irq results carry zero slot and bank and end their item
    a_irq_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_IRQ) |-> (o_slot == 3'd0 && o_bank == 8'd0 && o_last))
        else $error("irq result with nonzero fields");

    // program results only address slots 0..2, mirroring bank is one bit
    a_prog_mirror: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == KIND_PROGRAM || o_kind == KIND_MIRROR))
        |-> (o_slot != 3'd3 && o_slot[2] == 1'b0 && o_last
             && (o_kind != KIND_MIRROR || (o_bank[7:1] == 7'd0 && o_slot == 3'd0))))
        else $error("bad program or mirroring result");

    // a result that is not last is followed by the same kind and bank
    a_pair_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last)
        |=> (o_out_valid && o_last && o_kind == KIND_PATTERN
             && o_bank == $past(o_bank)))
        else $error("second pattern result missing after first");

endmodule

FILE: src/bsirq_front.sv
`timescale 1ns / 1ps
// front end: register decode, irq counter and job classification
module bsirq_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_action,
    input  logic [15:0]          i_address,
    input  logic [7:0]           i_value,
    input  logic [8:0]           i_scanline,
    input  logic                 i_render_on,
    input  bsirq_pkg::t_q_status i_q_status,
    output logic                 o_push,
    output bsirq_pkg::t_job      o_job
);
    import bsirq_pkg::*;

    logic [7:0] r_cmd, n_cmd;
    logic [7:0] r_count, n_count;
    logic [7:0] r_reload, n_reload;
    logic       r_irq_on, n_irq_on;
    logic       r_pend, n_pend;
    logic       accept;
    logic [2:0] x_flip;
    t_job       job;
    logic       has_job;

    assign o_in_stall = i_q_status.full;
    assign accept     = i_in_valid && !i_q_status.full;
    assign x_flip     = {r_cmd[7], 2'b00};

    always_comb begin
        n_cmd    = r_cmd;
        n_count  = r_count;
        n_reload = r_reload;
        n_irq_on = r_irq_on;
        n_pend   = r_pend;
        job      = '0;
        has_job  = 1'b0;
        job.bank = i_value;
        if (accept) begin
            if (!i_action) begin
                case (i_address & ADDR_MASK)
                    REG_COMMAND: n_cmd = i_value;
                    REG_DATA: begin
                        has_job  = 1'b1;
                        job.kind = KIND_PATTERN;
                        case (r_cmd[3:0])
                            CMD_PAT_PAIR0: begin
                                job.slot_a = 3'd0 ^ x_flip;
                                job.slot_b = 3'd1 ^ x_flip;
                                job.two    = 1'b1;
                            end
                            CMD_PAT_PAIR2: begin
                                job.slot_a = 3'd2 ^ x_flip;
                                job.slot_b = 3'd3 ^ x_flip;
                                job.two    = 1'b1;
                            end
                            CMD_PAT_4, CMD_PAT_5, CMD_PAT_6, CMD_PAT_7: begin
                                job.slot_a = (r_cmd[2:0] + 3'd2) ^ x_flip;
                            end
                            CMD_PRG_A: begin
                                job.kind   = KIND_PROGRAM;
                                job.slot_a = r_cmd[6] ? 3'd1 : 3'd0;
                            end
                            CMD_PRG_B: begin
                                job.kind   = KIND_PROGRAM;
                                job.slot_a = r_cmd[6] ? 3'd2 : 3'd1;
                            end
                            CMD_PAT_1: job.slot_a = 3'd1;
                            CMD_PAT_3: job.slot_a = 3'd3;
                            CMD_PRG_C: begin
                                job.kind   = KIND_PROGRAM;
                                job.slot_a = r_cmd[6] ? 3'd0 : 3'd2;
                            end
                            default: has_job = 1'b0;
                        endcase
                    end
                    REG_MIRROR: begin
                        has_job  = 1'b1;
                        job.kind = KIND_MIRROR;
                        job.bank = {7'd0, i_value[0]};
                    end
                    REG_RELOAD:     n_reload = i_value;
                    REG_RELOAD_REQ: n_pend   = 1'b1;
                    REG_IRQ_OFF:    n_irq_on = 1'b0;
                    REG_IRQ_ON:     n_irq_on = 1'b1;
                    default: ;
                endcase
                // pending reload copies after any write
                if (n_pend) begin
                    n_count = n_reload;
                end
            end else if (i_scanline < LINE_LIMIT) begin
                n_pend = 1'b0;
                if (i_render_on) begin
                    if (r_count == 8'd0) begin
                        n_count = r_reload;
                        n_pend  = 1'b1;
                        if (r_irq_on) begin
                            has_job  = 1'b1;
                            job.kind = KIND_IRQ;
                            job.bank = 8'd0;
                        end
                    end else begin
                        n_count = r_count - 8'd1;
                    end
                end
            end
        end
    end

    assign o_push = has_job;
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd    <= '0;
            r_count  <= '0;
            r_reload <= '0;
            r_irq_on <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_cmd    <= n_cmd;
            r_count  <= n_count;
            r_reload <= n_reload;
            r_irq_on <= n_irq_on;
            r_pend   <= n_pend;
        end
    end

endmodule

FILE: src/bsirq_queue.sv
`timescale 1ns / 1ps
// short job queue between front and back
module bsirq_queue #(
    parameter int DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  bsirq_pkg::t_job      i_job,
    input  logic                 i_pop,
    output bsirq_pkg::t_job      o_job,
    output bsirq_pkg::t_q_status o_status
);
    import bsirq_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_status.full  = (r_cnt == CW'(DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_job          = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

FILE: src/bsirq_back.sv
`timescale 1ns / 1ps
// back end: splits jobs into result items behind an output register
module bsirq_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bsirq_pkg::t_job      i_job,
    input  bsirq_pkg::t_q_status i_q_status,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_kind,
    output logic [2:0]           o_slot,
    output logic [7:0]           o_bank,
    output logic                 o_last
);
    import bsirq_pkg::*;

    logic       r_valid, n_valid;
    logic       r_second, n_second;
    t_kind      r_kind, n_kind;
    logic [2:0] r_slot, n_slot;
    logic [2:0] r_slot_b, n_slot_b;
    logic [7:0] r_bank, n_bank;
    logic       r_last, n_last;
    logic       out_free;

    assign out_free = !r_valid || !i_out_stall;

    always_comb begin
        n_valid  = r_valid;
        n_second = r_second;
        n_kind   = r_kind;
        n_slot   = r_slot;
        n_slot_b = r_slot_b;
        n_bank   = r_bank;
        n_last   = r_last;
        o_pop    = 1'b0;
        if (out_free) begin
            if (r_second) begin
                // second slot of a two-result write, same kind and bank
                n_valid  = 1'b1;
                n_slot   = r_slot_b;
                n_last   = 1'b1;
                n_second = 1'b0;
            end else if (!i_q_status.empty) begin
                o_pop    = 1'b1;
                n_valid  = 1'b1;
                n_kind   = i_job.kind;
                n_slot   = i_job.slot_a;
                n_slot_b = i_job.slot_b;
                n_bank   = i_job.bank;
                n_last   = !i_job.two;
                n_second = i_job.two;
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_second <= n_second;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_slot   <= n_slot;
        r_slot_b <= n_slot_b;
        r_bank   <= n_bank;
        r_last   <= n_last;
    end

    assign o_out_valid = r_valid;
    assign o_kind      = r_kind;
    assign o_slot      = r_slot;
    assign o_bank      = r_bank;
    assign o_last      = r_last;

endmodule
